FILE: hdl/tmtw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmtw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

endpackage

`default_nettype wire

FILE: hdl/text_mode_terminal_writer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Text-mode terminal with a ROWS x COLUMNS store of 16-bit cells (attribute
// in the high byte, character in the low byte) held in one synchronous RAM.
// A put of an ordinary character or a newline that stays on screen and a func 3
// beat are handled in S_IDLE; a read waits in S_READ for the registered RAM
// data. The next beat is taken as soon as the result register is free.
// A put that moves past the last row scrolls: S_COPY moves the rows up (one
// RAM read and one RAM write per cycle), a drain step lets the last copy
// write land, then S_BLANK blanks the bottom row.
// A clear writes one blank cell per cycle. After reset the same pass clears the
// store; in_tready stays low until it ends. The single RAM write port sets the
// pace of these passes.
module text_mode_terminal_writer_unit #(
  parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmtw_pkg::ROWS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // [7:0] character, [15:8] attribute, [26:16] cell_index, rest zero
  input  wire  [tmtw_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] func
  input  wire  [tmtw_pkg::FUNC_W-1:0]          in_tuser,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // [10:0] cursor_position, [11] scrolled, [27:12] read_word, rest zero
  output logic [tmtw_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CMP_W = (AW > tmtw_pkg::IDX_W) ? AW + 1 : tmtw_pkg::IDX_W + 1;

  localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] COL_STEP      = AW'(COLUMNS);
  localparam logic [AW-1:0] COPY_LAST     = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] BLANK_FIRST   = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FILL  = 5'b00010,
    S_READ  = 5'b00100,
    S_COPY  = 5'b01000,
    S_BLANK = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [tmtw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tmtw_pkg::CELL_W-1:0] rdata_r;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] wb_addr_r, wb_addr_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic          fill_res_r, fill_res_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [tmtw_pkg::ATTR_W-1:0] attr_r, attr_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [tmtw_pkg::POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic                          out_scr_r, out_scr_nxt;
  logic [tmtw_pkg::CELL_W-1:0]   out_word_r, out_word_nxt;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [tmtw_pkg::CELL_W-1:0]   mem_wdata;
  logic [AW-1:0]                 mem_raddr;

  logic                          accept;
  logic [tmtw_pkg::FUNC_W-1:0]   in_func;
  logic [tmtw_pkg::CHAR_W-1:0]   in_char;
  logic [tmtw_pkg::ATTR_W-1:0]   in_attr;
  logic [tmtw_pkg::IDX_W-1:0]    in_idx;
  logic                          wrap;

  assign in_func = in_tuser;
  assign in_char = in_tdata[7:0];
  assign in_attr = in_tdata[15:8];
  assign in_idx  = in_tdata[26:16];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign wrap      = (in_char == tmtw_pkg::NEWLINE_CHAR) || (col_r == LAST_COL);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    wb_addr_nxt   = wb_addr_r;
    wr_pend_nxt   = 1'b0;
    fill_res_nxt  = fill_res_r;
    rd_ok_nxt     = rd_ok_r;
    attr_nxt      = attr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_scr_nxt   = out_scr_r;
    out_word_nxt  = out_word_r;
    mem_raddr     = AW'(in_idx);
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = {in_attr, in_char};

    // pending copy write from the previous read
    if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wb_addr_r;
      mem_wdata = rdata_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_scr_nxt  = 1'b0;
          out_word_nxt = '0;
          unique case (in_func)
            tmtw_pkg::FUNC_PUT: begin
              if (in_char != tmtw_pkg::NEWLINE_CHAR) begin
                mem_we    = 1'b1;
                mem_waddr = pos_r;
                mem_wdata = {in_attr, in_char};
              end
              if (wrap) begin
                col_nxt = '0;
                if (row_r == LAST_ROW) begin
                  pos_nxt     = LAST_ROW_BASE;
                  attr_nxt    = in_attr;
                  cnt_nxt     = '0;
                  out_scr_nxt = 1'b1;
                  state_nxt   = S_COPY;
                end else begin
                  row_nxt       = row_r + 1'b1;
                  pos_nxt       = pos_r - AW'(col_r) + COL_STEP;
                  out_valid_nxt = 1'b1;
                end
              end else begin
                col_nxt       = col_r + 1'b1;
                pos_nxt       = pos_r + 1'b1;
                out_valid_nxt = 1'b1;
              end
            end
            tmtw_pkg::FUNC_CLEAR: begin
              row_nxt      = '0;
              col_nxt      = '0;
              pos_nxt      = '0;
              cnt_nxt      = '0;
              fill_res_nxt = 1'b1;
              state_nxt    = S_FILL;
            end
            tmtw_pkg::FUNC_READ: begin
              rd_ok_nxt = CMP_W'(in_idx) < CMP_W'(CELLS);
              state_nxt = S_READ;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_pos_nxt = tmtw_pkg::POS_W'(pos_nxt);
        end
      end
      S_READ: begin
        out_word_nxt  = rd_ok_r ? rdata_r : '0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_COPY: begin
        mem_raddr   = cnt_r + COL_STEP;
        wr_pend_nxt = 1'b1;
        wb_addr_nxt = cnt_r;
        if (cnt_r == COPY_LAST) begin
          cnt_nxt   = BLANK_FIRST;
          state_nxt = S_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_BLANK: begin
        if (!wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r;
          mem_wdata = {attr_r, tmtw_pkg::SPACE_CHAR};
          if (cnt_r == LAST_CELL) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = tmtw_pkg::BLANK_CELL;
        if (cnt_r == LAST_CELL) begin
          out_valid_nxt = fill_res_r;
          fill_res_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      row_r       <= '0;
      col_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      fill_res_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      fill_res_r  <= fill_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r  <= wb_addr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    attr_r     <= attr_nxt;
    out_pos_r  <= out_pos_nxt;
    out_scr_r  <= out_scr_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_word_r, out_scr_r, out_pos_r};

endmodule

`default_nettype wire

FILE: hdl/tmtw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tmtw_checker #(
  parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmtw_pkg::ROWS_DEF
) (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire [tmtw_pkg::IN_TDATA_W-1:0]   in_tdata,
  input wire [tmtw_pkg::FUNC_W-1:0]       in_tuser,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [tmtw_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam logic [tmtw_pkg::POS_W-1:0] LAST_ROW_POS =
    tmtw_pkg::POS_W'((ROWS - 1) * COLUMNS);
  localparam logic [tmtw_pkg::POS_W:0] CELLS_CMP = (tmtw_pkg::POS_W + 1)'(CELLS);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable({in_tuser, in_tdata}))
    else $error("input beat changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_no_take_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_tready)
    else $error("beat taken before the screen clear finished");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (CELLS <= 2048) |-> {1'b0, out_tdata[10:0]} < CELLS_CMP)
    else $error("cursor position beyond the screen");

  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[10:0] == LAST_ROW_POS)
    else $error("scroll left the cursor off the start of the last row");

endmodule

bind text_mode_terminal_writer_unit tmtw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tmtw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
